[sv/djq_pkg.sv]
// Shared types and codes for the deadline ordered job queue.
// No dependencies; used by djq_store and deadline_ordered_job_queue_core.
package djq_pkg;

    // Request selector carried on the input tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam int unsigned ID_BITS = 16;

    // Result kind carried on the output tuser
    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_IDLE   = 2'd3
    } t_kind;

    // Strobes from the sequencer to the job store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

[sv/deadline_ordered_job_queue_core.sv]
// Sorted timer queue: jobs held in a circular store in deadline order.
// Add: walks from the tail one entry per cycle, comparing every later deadline and the first one
// at or before it; a full queue rejects the job without comparing.
// Tick: pops every due job from the head in deadline order; output stalls hold it.
// One request in flight, ready only when idle: ready rises as the last result of a request is registered.
// Reset (synchronous, i_rst_n low) empties the queue; the store needs no clearing pass.
module deadline_ordered_job_queue_core #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata: when [TIME_BITS-1:0], job_id [TIME_BITS+15:TIME_BITS], zero pad
    input  logic [((TIME_BITS+djq_pkg::ID_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: cmd
    input  logic i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata: fired_id [15:0], fired_deadline [TIME_BITS+15:16], zero pad
    output logic [((TIME_BITS+djq_pkg::ID_BITS+7)/8)*8-1:0] o_m_tdata,
    // tuser: kind
    output logic [1:0] o_m_tuser,
    output logic o_m_tlast
);
    import djq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TIME_BITS + ID_BITS;
    localparam int DW = ((TIME_BITS + ID_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_START,
        S_A_CMP,
        S_A_PUT,
        S_T_START,
        S_T_CMP,
        S_T_LAST
    } t_state;

    t_state               r_state;
    logic [TIME_BITS-1:0] r_when;
    logic [ID_BITS-1:0]   r_id;
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic                 r_have;
    logic [TIME_BITS-1:0] r_cur_dl;
    logic [ID_BITS-1:0]   r_cur_id;

    logic                 r_ovalid;
    t_kind                r_okind;
    logic [ID_BITS-1:0]   r_oid;
    logic [TIME_BITS-1:0] r_odl;
    logic                 r_olast;

    t_mem_ctl             mem_ctl;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [EW-1:0]        wr_data;
    logic [EW-1:0]        rd_data;
    logic [TIME_BITS-1:0] rd_dl;
    logic [ID_BITS-1:0]   rd_id;
    logic                 later;
    logic                 out_free;
    logic                 s_accept;
    logic                 count_full;
    logic                 count_zero;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head, input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_dl      = rd_data[TIME_BITS-1:0];
    assign rd_id      = rd_data[EW-1:TIME_BITS];
    // Shared compare unit: stored deadline strictly later than the request time
    assign later      = rd_dl > r_when;
    assign out_free   = !r_ovalid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign count_full = (r_count == CW'(DEPTH));
    assign count_zero = (r_count == '0);

    always_comb begin
        mem_ctl = '0;
        wr_addr = wrap(r_head, AW'(r_idx));
        wr_data = {r_id, r_when};
        rd_addr = r_head;
        unique case (r_state)
            S_A_START: begin
                if (!count_full && !count_zero) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = wrap(r_head, AW'(r_count - 1'b1));
                end
            end
            S_A_CMP: begin
                // Shift the later entry up one slot and fetch the one below it
                if (later) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_data       = rd_data;
                    if (r_idx > CW'(1)) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = wrap(r_head, AW'(r_idx - CW'(2)));
                    end
                end
            end
            S_A_PUT: begin
                mem_ctl.wr_en = out_free;
            end
            S_T_START: begin
                mem_ctl.rd_en = !count_zero;
            end
            S_T_CMP: begin
                if (out_free && !later && r_count > CW'(1)) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = wrap(r_head, AW'(1));
                end
            end
            default: begin
                mem_ctl = '0;
            end
        endcase
    end

    djq_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_when  <= i_s_tdata[TIME_BITS-1:0];
                        r_id    <= i_s_tdata[TIME_BITS +: ID_BITS];
                        r_have  <= 1'b0;
                        r_state <= (i_s_tuser == CMD_ADD) ? S_A_START : S_T_START;
                    end
                end
                S_A_START: begin
                    r_idx <= r_count;
                    if (count_full) begin
                        // Drop the job, store unchanged
                        if (out_free) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= KIND_FULL;
                            r_oid    <= '0;
                            r_odl    <= '0;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else if (count_zero) begin
                        r_state <= S_A_PUT;
                    end else begin
                        r_state <= S_A_CMP;
                    end
                end
                S_A_CMP: begin
                    if (later) begin
                        r_idx <= r_idx - 1'b1;
                        if (r_idx == CW'(1)) begin
                            r_state <= S_A_PUT;
                        end
                    end else begin
                        r_state <= S_A_PUT;
                    end
                end
                S_A_PUT: begin
                    if (out_free) begin
                        r_count  <= r_count + 1'b1;
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_ACCEPT;
                        r_oid    <= '0;
                        r_odl    <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_T_START: begin
                    if (count_zero) begin
                        if (out_free) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= KIND_IDLE;
                            r_oid    <= '0;
                            r_odl    <= '0;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_T_CMP;
                    end
                end
                S_T_CMP: begin
                    // Hold the previous fired job until the next entry tells if it was the last
                    if (out_free) begin
                        if (r_have) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= KIND_FIRED;
                            r_oid    <= r_cur_id;
                            r_odl    <= r_cur_dl;
                            r_olast  <= later;
                        end else if (later) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= KIND_IDLE;
                            r_oid    <= '0;
                            r_odl    <= '0;
                            r_olast  <= 1'b1;
                        end
                        if (later) begin
                            r_state <= S_IDLE;
                        end else begin
                            // Pop the head into the pending slot
                            r_have   <= 1'b1;
                            r_cur_dl <= rd_dl;
                            r_cur_id <= rd_id;
                            r_count  <= r_count - 1'b1;
                            r_head   <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                            if (r_count == CW'(1)) begin
                                r_state <= S_T_LAST;
                            end
                        end
                    end
                end
                S_T_LAST: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_FIRED;
                        r_oid    <= r_cur_id;
                        r_odl    <= r_cur_dl;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = DW'({r_odl, r_oid});
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job count above depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_PUT && out_free) |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted add did not grow the queue");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_START && count_full) |=> r_count == $past(r_count))
        else $error("rejected add changed the queue");

    a_tick_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_CMP) |=> r_count <= $past(r_count))
        else $error("tick grew the queue");

endmodule

[sv/djq_store.sv]
// Job store: one write port and one read port with registered read data.
// Depends on djq_pkg for the strobe struct.
module djq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  djq_pkg::t_mem_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    import djq_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[test/tb.sv]
// Testbench for deadline_ordered_job_queue_core: a directed table, then random add and tick
// requests, checked report by report against a sorted job list kept here.
// Depends on djq_pkg and deadline_ordered_job_queue_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import djq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int TIME_W        = 48;
    localparam int DATA_W        = ((TIME_W + ID_BITS + 7) / 8) * 8;
    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ROWS   = 134;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        t_kind               kind;
        logic [ID_BITS-1:0]  fired_id;
        logic [TIME_W-1:0]   fired_deadline;
        logic                last;
    } t_report;

    // typed set: the row's single report is given by kind, with zero id and deadline
    typedef struct packed {
        logic                cmd;
        logic [TIME_W-1:0]   stamp;
        logic [ID_BITS-1:0]  job;
        logic                typed;
        t_kind               kind;
    } t_request_row;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;  // when, job_id, zero pad
    logic              i_s_tuser  = CMD_ADD;  // cmd
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;  // fired_id, fired_deadline, zero pad
    logic [1:0]        o_m_tuser;  // kind
    logic              o_m_tlast;

    deadline_ordered_job_queue_core #(
        .DEPTH     (QUEUE_DEPTH),
        .TIME_BITS (TIME_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_request_row directed_rows [DIRECTED_ROWS] = '{
        '{CMD_TICK, 48'd0,              16'h0000, 1'b1, KIND_IDLE},
        '{CMD_ADD,  48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd0,              16'h0000, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd5,              16'h0001, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd5,              16'h0002, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd5,              16'h0003, 1'b1, KIND_ACCEPT},
        '{CMD_TICK, 48'd4,              16'h0000, 1'b0, KIND_ACCEPT},
        '{CMD_TICK, 48'd3,              16'hFFFF, 1'b1, KIND_IDLE},
        // equal deadlines leave in arrival order
        '{CMD_TICK, 48'd5,              16'h0000, 1'b0, KIND_ACCEPT},
        '{CMD_ADD,  48'hFFFF_FFFF_FFFF, 16'h8000, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'h8000_0000_0000, 16'h1234, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'h7FFF_FFFF_FFFF, 16'h4321, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd100,            16'h00A0, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd100,            16'h00A1, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd99,             16'h0099, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd1,              16'h0F0F, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'hAAAA_AAAA_AAAA, 16'hAAAA, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'h5555_5555_5555, 16'h5555, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd0,              16'hF0F0, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd0,              16'h0050, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd50,             16'h7FFE, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'hFFFF_FFFF_FFFE, 16'h0007, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd7,              16'h0200, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd200,            16'hC3C3, 1'b1, KIND_ACCEPT},
        '{CMD_ADD,  48'd10,             16'hBEEF, 1'b1, KIND_FULL},
        // store full: a tick at the latest time drains all of it
        '{CMD_TICK, 48'hFFFF_FFFF_FFFF, 16'h0000, 1'b0, KIND_ACCEPT}
    };

    logic [TIME_W-1:0]  held_deadline [$];
    logic [ID_BITS-1:0] held_id [$];
    t_report            step_reports [$];
    t_report            awaited_reports [$];

    bit quiet = 1'b0;
    int n_fail = 0;
    int n_requests = 0;
    int n_by_kind [4] = '{0, 0, 0, 0};

    // Apply one request to the local job list and collect the reports it causes.
    task automatic apply_request(input logic cmd, input logic [TIME_W-1:0] stamp,
                                 input logic [ID_BITS-1:0] job);
        int pos;
        int due;
        int k;
        step_reports.delete();
        if (cmd == CMD_ADD) begin
            if (held_deadline.size() >= QUEUE_DEPTH) begin
                step_reports.push_back('{KIND_FULL, '0, '0, 1'b1});
            end else begin
                pos = 0;
                while (pos < held_deadline.size() && held_deadline[pos] <= stamp) pos++;
                held_deadline.insert(pos, stamp);
                held_id.insert(pos, job);
                step_reports.push_back('{KIND_ACCEPT, '0, '0, 1'b1});
            end
        end else begin
            due = 0;
            while (due < held_deadline.size() && held_deadline[due] <= stamp) due++;
            if (due == 0) begin
                step_reports.push_back('{KIND_IDLE, '0, '0, 1'b1});
            end else begin
                for (k = 0; k < due; k++) begin
                    step_reports.push_back('{KIND_FIRED, held_id[0], held_deadline[0],
                                             (k == due - 1)});
                    void'(held_id.pop_front());
                    void'(held_deadline.pop_front());
                end
            end
        end
    endtask

    task automatic send_request(input logic cmd, input logic [TIME_W-1:0] stamp,
                                input logic [ID_BITS-1:0] job, input logic typed,
                                input t_kind typed_kind);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {job, stamp};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        apply_request(cmd, stamp, job);
        if (typed)
            awaited_reports.push_back('{typed_kind, '0, '0, 1'b1});
        else
            foreach (step_reports[n]) awaited_reports.push_back(step_reports[n]);
        n_requests++;
    endtask

    initial begin
        int                 k;
        int unsigned        pick;
        logic               cmd;
        logic [TIME_W-1:0]  stamp;
        logic [TIME_W-1:0]  clock_now;
        logic [ID_BITS-1:0] job;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_request(directed_rows[k].cmd, directed_rows[k].stamp, directed_rows[k].job,
                         directed_rows[k].typed, directed_rows[k].kind);

        // Deadlines mostly just ahead of a running time, so ticks keep firing jobs.
        clock_now = TIME_W'($urandom_range(0, 1000));
        for (k = 0; k < RANDOM_ROWS; k++) begin
            quiet = ((k % 80) >= 60);
            // jump close to the top of the time range so later deadlines wrap
            if (k == 80) clock_now = '1 - TIME_W'($urandom_range(0, 400));
            pick = $urandom_range(0, 99);
            // fill the store in one burst
            if (k >= 100 && k < 120) pick = 0;
            job = ID_BITS'($urandom_range(0, 65535));
            if (pick < 55) begin
                cmd = CMD_ADD;
                if ($urandom_range(0, 6) == 0)
                    stamp = {16'($urandom), $urandom};
                else
                    stamp = clock_now + TIME_W'($urandom_range(0, 60));
            end else begin
                cmd = CMD_TICK;
                if (pick >= 92) begin
                    stamp = {16'($urandom), $urandom};
                end else begin
                    clock_now = clock_now + TIME_W'($urandom_range(0, 40));
                    stamp = clock_now;
                end
            end
            send_request(cmd, stamp, job, 1'b0, KIND_ACCEPT);
        end
        i_s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests (%0d from the directed table) through the job queue",
                 n_requests, DIRECTED_ROWS);
        $display("reports: %0d accepted, %0d rejected full, %0d fired, %0d nothing due",
                 n_by_kind[KIND_ACCEPT], n_by_kind[KIND_FULL], n_by_kind[KIND_FIRED],
                 n_by_kind[KIND_IDLE]);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned stall;
        t_report     want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            if (awaited_reports.size() == 0) begin
                $error("report with none awaited: kind %0d id %0h deadline %0h last %0b",
                       o_m_tuser, o_m_tdata[ID_BITS-1:0],
                       o_m_tdata[ID_BITS+TIME_W-1:ID_BITS], o_m_tlast);
                n_fail++;
            end else begin
                want = awaited_reports.pop_front();
                n_by_kind[want.kind]++;
                if (o_m_tuser !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_m_tuser);
                    n_fail++;
                end
                if (o_m_tdata[ID_BITS-1:0] !== want.fired_id) begin
                    $error("fired_id: expected %0h, actual %0h",
                           want.fired_id, o_m_tdata[ID_BITS-1:0]);
                    n_fail++;
                end
                if (o_m_tdata[ID_BITS+TIME_W-1:ID_BITS] !== want.fired_deadline) begin
                    $error("fired_deadline: expected %0h, actual %0h",
                           want.fired_deadline, o_m_tdata[ID_BITS+TIME_W-1:ID_BITS]);
                    n_fail++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_m_tlast);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
